FILE: rtl/bbba_pkg.sv
// Shared types and constants for the base 10^9 bignum ALU.
// Depends on nothing; used by bbba_cell and base_billion_bignum_alu.
package bbba_pkg;

  localparam int LIMBS  = 4;
  localparam int LIMB_W = 30;
  localparam int CY_W   = 2;
  localparam int SUM_W  = LIMB_W + 2;

  localparam logic [LIMB_W-1:0] LIMB_BASE = LIMB_W'(1000000000);
  localparam logic [SUM_W-1:0]  BASE_1X   = SUM_W'(64'd1000000000);
  localparam logic [SUM_W-1:0]  BASE_2X   = SUM_W'(64'd2000000000);
  localparam logic [SUM_W-1:0]  BASE_3X   = SUM_W'(64'd3000000000);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_RED   = 2'd2,
    OP_HALVE = 2'd3
  } op_t;

  typedef logic [LIMBS-1:0][LIMB_W-1:0] limbs_t;

  typedef struct packed {
    op_t             op;
    logic [CY_W-1:0] cy;
    limbs_t          a;
    limbs_t          b;
    limbs_t          r;
  } item_t;

endpackage

FILE: rtl/bbba_cell.sv
// One pipeline cell: works out result limb IDX and passes carry/borrow upward.
// Depends on bbba_pkg.
module bbba_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  bbba_pkg::item_t up_item,
  output logic            dn_valid,
  input  logic            dn_ready,
  output bbba_pkg::item_t dn_item
);

  localparam int HI = (IDX < bbba_pkg::LIMBS - 1) ? IDX + 1 : IDX;

  logic                                   vld_r;
  bbba_pkg::item_t                        item_r;
  bbba_pkg::item_t                        item_nxt;
  logic [bbba_pkg::LIMB_W-1:0]            a_i;
  logic [bbba_pkg::LIMB_W-1:0]            b_i;
  logic                                   hi_bit;
  logic [bbba_pkg::SUM_W-1:0]             sum;
  logic [bbba_pkg::SUM_W-1:0]             dif;
  logic [bbba_pkg::SUM_W-1:0]             red;
  logic [bbba_pkg::LIMB_W:0]              half;
  logic [bbba_pkg::LIMB_W-1:0]            res;
  logic [bbba_pkg::CY_W-1:0]              cy_out;
  logic                                   take;

  assign a_i    = up_item.a[IDX];
  assign b_i    = up_item.b[IDX];
  assign hi_bit = (IDX < bbba_pkg::LIMBS - 1) ? up_item.a[HI][0] : 1'b0;

  assign sum  = {2'b00, a_i} + {2'b00, b_i}
              + {{(bbba_pkg::SUM_W-bbba_pkg::CY_W){1'b0}}, up_item.cy};
  assign dif  = {2'b00, a_i} + bbba_pkg::BASE_2X - {2'b00, b_i}
              - {{(bbba_pkg::SUM_W-1){1'b0}}, up_item.cy[0]};
  assign half = ({1'b0, a_i} + (hi_bit ? {1'b0, bbba_pkg::LIMB_BASE}
                                       : {(bbba_pkg::LIMB_W+1){1'b0}})) >> 1;

  always_comb begin
    red    = '0;
    res    = '0;
    cy_out = '0;
    unique case (up_item.op)
      bbba_pkg::OP_ADD: begin
        if (sum >= bbba_pkg::BASE_2X) begin
          red    = sum - bbba_pkg::BASE_2X;
          cy_out = 2'd2;
        end else if (sum >= bbba_pkg::BASE_1X) begin
          red    = sum - bbba_pkg::BASE_1X;
          cy_out = 2'd1;
        end else begin
          red    = sum;
        end
        res = red[bbba_pkg::LIMB_W-1:0];
      end
      bbba_pkg::OP_SUB, bbba_pkg::OP_RED: begin
        if (dif >= bbba_pkg::BASE_3X) begin
          red = dif - bbba_pkg::BASE_3X;
        end else if (dif >= bbba_pkg::BASE_2X) begin
          red = dif - bbba_pkg::BASE_2X;
        end else if (dif >= bbba_pkg::BASE_1X) begin
          red = dif - bbba_pkg::BASE_1X;
        end else begin
          red = dif;
        end
        cy_out = {1'b0, (dif < bbba_pkg::BASE_2X)};
        res    = red[bbba_pkg::LIMB_W-1:0];
      end
      bbba_pkg::OP_HALVE: begin
        res = half[bbba_pkg::LIMB_W-1:0];
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_comb begin
    item_nxt        = up_item;
    item_nxt.cy     = cy_out;
    item_nxt.r[IDX] = res;
  end

  assign up_ready = ~vld_r | dn_ready;
  assign take     = up_valid & up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_item  = item_r;

endmodule

FILE: rtl/base_billion_bignum_alu.sv
// Top level of the base 10^9 bignum ALU: a row of limb cells and an output register.
// Depends on bbba_pkg and bbba_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: an opcode and operands
//   a and b as four base 10^9 limbs, least significant first.
//   Opcodes: add, subtract (both wrap mod 10^36), reduce (a if a < b, else
//   a - b) and halve a. Result channel (out_valid/out_ready) returns one word
//   per input word: four result limbs plus flags a_odd and a_zero.
//   Each cell handles one limb and hands carry or borrow to the next cell, so
//   a word passes LIMBS + 1 = 5 registers: four cells, then the output register.
//   Absent a stall, a new word is accepted every cycle, one word per clock.
//   Reduce uses the final borrow of the subtract chain as the a < b compare.
//   When the receiver stalls, each stage holds its word and in_ready drops
//   only once every stage is full; empty stages still fill behind a stall.
//   Synchronous active-low reset empties the pipeline; no words are lost or
//   produced by reset other than those in flight being discarded.
module base_billion_bignum_alu (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_opcode,
  input  logic [bbba_pkg::LIMB_W-1:0] in_a_limb0,
  input  logic [bbba_pkg::LIMB_W-1:0] in_a_limb1,
  input  logic [bbba_pkg::LIMB_W-1:0] in_a_limb2,
  input  logic [bbba_pkg::LIMB_W-1:0] in_a_limb3,
  input  logic [bbba_pkg::LIMB_W-1:0] in_b_limb0,
  input  logic [bbba_pkg::LIMB_W-1:0] in_b_limb1,
  input  logic [bbba_pkg::LIMB_W-1:0] in_b_limb2,
  input  logic [bbba_pkg::LIMB_W-1:0] in_b_limb3,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bbba_pkg::LIMB_W-1:0] out_r_limb0,
  output logic [bbba_pkg::LIMB_W-1:0] out_r_limb1,
  output logic [bbba_pkg::LIMB_W-1:0] out_r_limb2,
  output logic [bbba_pkg::LIMB_W-1:0] out_r_limb3,
  output logic                        out_a_odd,
  output logic                        out_a_zero
);

  logic            vld   [bbba_pkg::LIMBS+1];
  logic            rdy   [bbba_pkg::LIMBS+1];
  bbba_pkg::item_t chain [bbba_pkg::LIMBS+1];

  bbba_pkg::item_t in_item;
  logic            out_vld_r;
  bbba_pkg::limbs_t out_r_r;
  logic            odd_r;
  logic            zero_r;
  bbba_pkg::item_t last;
  logic            out_take;

  always_comb begin
    in_item      = '0;
    in_item.op   = bbba_pkg::op_t'(in_opcode);
    in_item.cy   = '0;
    in_item.a[0] = in_a_limb0;
    in_item.a[1] = in_a_limb1;
    in_item.a[2] = in_a_limb2;
    in_item.a[3] = in_a_limb3;
    in_item.b[0] = in_b_limb0;
    in_item.b[1] = in_b_limb1;
    in_item.b[2] = in_b_limb2;
    in_item.b[3] = in_b_limb3;
  end

  assign chain[0] = in_item;
  assign vld[0]   = in_valid;
  assign in_ready = rdy[0];

  for (genvar g = 0; g < bbba_pkg::LIMBS; g++) begin : g_cell
    bbba_cell #(
      .IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[g]),
      .up_ready (rdy[g]),
      .up_item  (chain[g]),
      .dn_valid (vld[g+1]),
      .dn_ready (rdy[g+1]),
      .dn_item  (chain[g+1])
    );
  end

  // reduce: final borrow set means a < b, so pass a through
  assign last                 = chain[bbba_pkg::LIMBS];
  assign rdy[bbba_pkg::LIMBS] = ~out_vld_r | out_ready;
  assign out_take             = vld[bbba_pkg::LIMBS] & rdy[bbba_pkg::LIMBS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rdy[bbba_pkg::LIMBS]) begin
      out_vld_r <= vld[bbba_pkg::LIMBS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_r_r <= (last.op == bbba_pkg::OP_RED && last.cy[0]) ? last.a : last.r;
      odd_r   <= last.a[0][0];
      zero_r  <= ~|last.a;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_r_limb0 = out_r_r[0];
  assign out_r_limb1 = out_r_r[1];
  assign out_r_limb2 = out_r_r[2];
  assign out_r_limb3 = out_r_r[3];
  assign out_a_odd   = odd_r;
  assign out_a_zero  = zero_r;

endmodule
